// ===== src/rts_pkg.sv =====
// shared types and constants for the ready task selector
// item and result structs, operation and status codes, controller/datapath bundles
// no dependencies
`timescale 1ns / 1ps

package rts_pkg;

  // default sizing handed to the top-level parameters
  localparam int TASK_SLOTS_DEF = 64;
  localparam int TICK_BITS_DEF  = 8;

  // width of task_slot and running_slot fields
  localparam int TASK_FIELD_W = 7;

  // operation codes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_BLOCK   = 2'd1;
  localparam logic [1:0] OP_UNBLOCK = 2'd2;
  localparam logic [1:0] OP_YIELD   = 2'd3;

  // task state codes
  localparam logic [2:0] ST_READY   = 3'd0;
  localparam logic [2:0] ST_RUNNING = 3'd1;

  // result status codes
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_NO_READY  = 3'd2,
    STS_BAD_STATE = 3'd3,
    STS_BAD_SLOT  = 3'd4
  } status_t;

  // input item
  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] task_slot;
    logic [7:0] priority_req;
    logic [2:0] block_state;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] created_slot;
    logic [6:0] running_slot;
    logic       switched;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    cnt_inc;
    logic    claim;
    logic    scan;
    logic    wr_tgt;
    logic    wr_old;
    logic    wr_new;
    logic    finish;
    status_t status;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       tgt_valid;
    logic       bst_bad;
    logic       tgt_is_cur;
    logic       slot_free;
    logic       cnt_last;
    logic       scan_end;
    logic       found;
  } dp_stat_t;

endpackage

// ===== src/rts_datapath.sv =====
// datapath of the ready task selector: slot tables, scan counter, best-slot tracking
// and the result register; driven by rts_controller through ctl_cmd_t
// depends on rts_pkg
`timescale 1ns / 1ps

module rts_datapath #(
  parameter int TASK_SLOTS = 64,
  parameter int TICK_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rts_pkg::in_item_t  in_item,
  input  rts_pkg::ctl_cmd_t  cmd,
  output rts_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output rts_pkg::out_item_t out_item
);
  import rts_pkg::*;

  localparam int IDX_W  = $clog2(TASK_SLOTS);
  localparam int SLOT_W = $clog2(TASK_SLOTS + 1);
  localparam int CMP_W  = (SLOT_W > TASK_FIELD_W) ? SLOT_W : TASK_FIELD_W;
  localparam logic [SLOT_W-1:0] BOOT_SLOT = SLOT_W'(TASK_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [CMP_W-1:0]  BOOT_CMP  = CMP_W'(TASK_SLOTS);

  in_item_t              item_r;
  logic [SLOT_W-1:0]     cnt_r;
  logic [TASK_SLOTS-1:0] used_r;
  logic [SLOT_W-1:0]     current_r;
  logic [IDX_W-1:0]      best_r;
  logic [TICK_BITS-1:0]  best_ticks_r;
  logic                  found_r;
  logic [IDX_W-1:0]      created_r;
  logic                  switched_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  rd_vld_r;
  logic [2:0]            st_rdata_r;
  logic [TICK_BITS-1:0]  tk_rdata_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [2:0]            st_mem [TASK_SLOTS];
  logic [TICK_BITS-1:0]  tk_mem [TASK_SLOTS];

  logic [IDX_W-1:0]      cnt_idx;
  logic [CMP_W-1:0]      tgt_w;
  logic [IDX_W-1:0]      tgt_idx;
  logic [2:0]            wr_val;
  logic                  scan_issue;
  logic                  cand;
  logic                  st_we;
  logic [IDX_W-1:0]      st_waddr;
  logic [2:0]            st_wdata;

  assign cnt_idx = cnt_r[IDX_W-1:0];
  assign tgt_w   = CMP_W'(item_r.task_slot);
  assign tgt_idx = tgt_w[IDX_W-1:0];

  // block writes the waiting state, everything else writes ready
  assign wr_val = (item_r.operation == OP_BLOCK) ? item_r.block_state : ST_READY;

  // status toward the controller
  always_comb begin
    stat.op         = item_r.operation;
    stat.tgt_valid  = (tgt_w == BOOT_CMP) || ((tgt_w < BOOT_CMP) && used_r[tgt_idx]);
    stat.bst_bad    = (item_r.block_state == ST_READY) || (item_r.block_state == ST_RUNNING);
    stat.tgt_is_cur = (tgt_w == CMP_W'(current_r));
    stat.slot_free  = (cnt_r != BOOT_SLOT) && !used_r[cnt_idx];
    stat.cnt_last   = (cnt_r == LAST_SLOT);
    stat.scan_end   = (cnt_r == BOOT_SLOT);
    stat.found      = found_r;
  end

  // state table write port select
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cnt_idx;
    st_wdata = ST_READY;
    priority if (cmd.claim) begin
      st_we = 1'b1;
    end else if (cmd.wr_tgt) begin
      st_we    = (tgt_w != BOOT_CMP);
      st_waddr = tgt_idx;
      st_wdata = wr_val;
    end else if (cmd.wr_old) begin
      st_we    = (current_r != BOOT_SLOT);
      st_waddr = current_r[IDX_W-1:0];
      st_wdata = wr_val;
    end else if (cmd.wr_new) begin
      st_we    = 1'b1;
      st_waddr = best_r;
      st_wdata = ST_RUNNING;
    end
  end

  // state and ticks tables, one read address driven by the scan counter
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (cmd.claim) begin
      tk_mem[cnt_idx] <= TICK_BITS'(item_r.priority_req);
    end
    st_rdata_r <= st_mem[cnt_idx];
    tk_rdata_r <= tk_mem[cnt_idx];
  end

  // scan pipeline: read issued one cycle, compared the next
  assign scan_issue = cmd.scan && (cnt_r != BOOT_SLOT);
  assign cand = rd_vld_r && used_r[rd_idx_r] && (st_rdata_r == ST_READY) &&
                (SLOT_W'(rd_idx_r) != current_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
    end
    rd_idx_r <= cnt_idx;
  end

  // item latch, counter and best-slot tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_item;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      created_r  <= '0;
      switched_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc || scan_issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.claim) begin
        created_r <= cnt_idx;
      end
      if (cmd.wr_new) begin
        switched_r <= 1'b1;
      end
      if (cand && (!found_r || (best_ticks_r < tk_rdata_r))) begin
        found_r      <= 1'b1;
        best_r       <= rd_idx_r;
        best_ticks_r <= tk_rdata_r;
      end
    end
  end

  // used map and running task
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      current_r <= BOOT_SLOT;
    end else begin
      if (cmd.claim) begin
        used_r[cnt_idx] <= 1'b1;
      end
      if (cmd.wr_new) begin
        current_r <= SLOT_W'(best_r);
      end
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_r.status       <= cmd.status;
      out_r.created_slot <= 6'(created_r);
      out_r.running_slot <= 7'(current_r);
      out_r.switched     <= switched_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== src/rts_controller.sv =====
// controller of the ready task selector: decodes an operation and sequences the
// free-slot search, the ready-slot scan and the task switch
// depends on rts_pkg
`timescale 1ns / 1ps

module rts_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rts_pkg::dp_stat_t stat,
  output rts_pkg::ctl_cmd_t cmd
);
  import rts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_FREE   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_SEL    = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    busy       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = STS_OK;
        state_nxt  = S_DONE;
        unique case (stat.op)
          OP_CREATE: state_nxt = S_FREE;
          OP_BLOCK: begin
            priority if (!stat.tgt_valid) begin
              status_nxt = STS_BAD_SLOT;
            end else if (stat.bst_bad) begin
              status_nxt = STS_BAD_STATE;
            end else if (stat.tgt_is_cur) begin
              state_nxt = S_SCAN;
            end else begin
              cmd.wr_tgt = 1'b1;
            end
          end
          OP_UNBLOCK: begin
            if (!stat.tgt_valid) begin
              status_nxt = STS_BAD_SLOT;
            end else begin
              cmd.wr_tgt = 1'b1;
            end
          end
          default: state_nxt = S_SCAN;
        endcase
      end
      // one slot of the used map per cycle
      S_FREE: begin
        priority if (stat.slot_free) begin
          cmd.claim  = 1'b1;
          status_nxt = STS_OK;
          state_nxt  = S_DONE;
        end else if (stat.cnt_last) begin
          status_nxt = STS_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      // one table entry per cycle, last compare lands on the exit cycle
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (!stat.found) begin
          status_nxt = STS_NO_READY;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_old = 1'b1;
          state_nxt  = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.wr_new = 1'b1;
        status_nxt = STS_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    status_r <= status_nxt;
  end

endmodule

// ===== src/ready_task_selector_unit.sv =====
// top level of the ready task selector: controller plus datapath
// depends on rts_pkg, rts_controller and rts_datapath
`timescale 1ns / 1ps

// Usage
//   Input: drive in_item and raise start; the item transfers at a rising edge
//   with start high and busy low. busy stays high until the result is issued.
//   Output: out_valid is high for exactly one cycle with out_item; the receiver
//   cannot stall, it must take the result in that cycle.
//   States passed from the transfer edge to the out_valid cycle:
//     bad slot, bad state, unblock, block of a task not running: DECODE, DONE
//     create: DECODE, FREE search up to the claimed slot or the last one, DONE
//     yield or block of the running task: DECODE, SCAN of all TASK_SLOTS, SEL,
//     then COMMIT when a switch happens, and DONE.
//   One item is in flight at a time; the next may transfer in the cycle that
//   carries out_valid. Schedule cost is set by the scan of the state and ticks
//   tables, one entry per cycle through their single read port.
//   Reset: the used map is cleared, the boot task runs, no result is pending.
//   No clearing pass is needed after reset.

module ready_task_selector_unit #(
  parameter int TASK_SLOTS = rts_pkg::TASK_SLOTS_DEF,
  parameter int TICK_BITS  = rts_pkg::TICK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rts_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rts_pkg::out_item_t out_item
);
  import rts_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing
  rts_controller u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // tables and result register
  rts_datapath #(
    .TASK_SLOTS (TASK_SLOTS),
    .TICK_BITS  (TICK_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/rts_outcome_tracker.sv =====
// scoreboard for the ready task selector: task table prediction and result check
// depends on rts_pkg for the item/result structs and the operation/status codes
`timescale 1ns / 1ps

package rts_tb_pkg;

  import rts_pkg::*;

  localparam int         SLOTS     = TASK_SLOTS_DEF;
  localparam logic [6:0] BOOT_TASK = 7'(SLOTS);

  class rts_outcome_tracker;

    // predicted task table
    bit         used_map   [SLOTS];
    logic [2:0] task_state [SLOTS];
    logic [7:0] task_ticks [SLOTS];
    logic [6:0] cur_task;
    logic [2:0] boot_state;

    // results still owed by the block, oldest first
    out_item_t pending_outcomes[$];

    int unsigned error_count;
    int unsigned op_hits[4];
    int unsigned status_hits[5];
    int unsigned switch_count;

    function new();
      foreach (used_map[i]) begin
        used_map[i]   = 1'b0;
        task_state[i] = ST_READY;
        task_ticks[i] = '0;
      end
      cur_task    = BOOT_TASK;
      boot_state  = ST_RUNNING;
      error_count = 0;
      switch_count = 0;
      foreach (op_hits[i]) op_hits[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function bit target_ok(logic [6:0] t);
      if (t == BOOT_TASK) return 1'b1;
      if (t > BOOT_TASK) return 1'b0;
      return used_map[int'(t)];
    endfunction

    function logic [2:0] get_state(logic [6:0] t);
      return (t == BOOT_TASK) ? boot_state : task_state[int'(t)];
    endfunction

    function void set_state(logic [6:0] t, logic [2:0] s);
      if (t == BOOT_TASK) boot_state = s;
      else if (t < BOOT_TASK) task_state[int'(t)] = s;
    endfunction

    // highest ticks among ready slots other than the running one, lowest index on a tie
    function logic [6:0] pick_next();
      logic [6:0] best;
      best = BOOT_TASK;
      for (int i = 0; i < SLOTS; i++) begin
        if (!used_map[i] || task_state[i] != ST_READY || i == int'(cur_task)) continue;
        if (best == BOOT_TASK || task_ticks[int'(best)] < task_ticks[i]) best = 7'(i);
      end
      return best;
    endfunction

    function void switch_to(logic [6:0] nxt);
      if (get_state(cur_task) == ST_RUNNING) set_state(cur_task, ST_READY);
      set_state(nxt, ST_RUNNING);
      cur_task = nxt;
    endfunction

    // apply one command to the table and build the result it should give
    function out_item_t predict_outcome(in_item_t it);
      out_item_t  r;
      logic [6:0] nxt;
      r = '0;
      r.status = STS_OK;
      case (it.operation)
        OP_CREATE: begin
          r.status = STS_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!used_map[i]) begin
              used_map[i]    = 1'b1;
              task_state[i]  = ST_READY;
              task_ticks[i]  = it.priority_req;
              r.created_slot = 6'(i);
              r.status       = STS_OK;
              break;
            end
          end
        end
        OP_BLOCK: begin
          if (!target_ok(it.task_slot)) begin
            r.status = STS_BAD_SLOT;
          end else if (it.block_state == ST_READY || it.block_state == ST_RUNNING) begin
            r.status = STS_BAD_STATE;
          end else if (it.task_slot == cur_task) begin
            nxt = pick_next();
            if (nxt == BOOT_TASK) begin
              // nothing else to run: the block is dropped as well
              r.status = STS_NO_READY;
            end else begin
              set_state(it.task_slot, it.block_state);
              switch_to(nxt);
              r.switched = 1'b1;
            end
          end else begin
            set_state(it.task_slot, it.block_state);
          end
        end
        OP_UNBLOCK: begin
          if (!target_ok(it.task_slot)) r.status = STS_BAD_SLOT;
          else set_state(it.task_slot, ST_READY);
        end
        default: begin
          nxt = pick_next();
          if (nxt == BOOT_TASK) begin
            r.status = STS_NO_READY;
          end else begin
            switch_to(nxt);
            r.switched = 1'b1;
          end
        end
      endcase
      r.running_slot = cur_task;
      return r;
    endfunction

    // called on each accepted command transfer
    function void take_command(in_item_t it);
      out_item_t r;
      r = predict_outcome(it);
      pending_outcomes.push_back(r);
      op_hits[int'(it.operation)]++;
      if (int'(r.status) < 5) status_hits[int'(r.status)]++;
      if (r.switched) switch_count++;
    endfunction

    // called on each result transfer
    function void check_outcome(out_item_t got);
      out_item_t exp_r;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %h", $time, got);
        error_count++;
        return;
      end
      exp_r = pending_outcomes.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, exp_r.status, got.status);
        error_count++;
      end
      if (got.created_slot !== exp_r.created_slot) begin
        $display("%0t: created_slot mismatch, expected %0d, got %0d",
                 $time, exp_r.created_slot, got.created_slot);
        error_count++;
      end
      if (got.running_slot !== exp_r.running_slot) begin
        $display("%0t: running_slot mismatch, expected %0d, got %0d",
                 $time, exp_r.running_slot, got.running_slot);
        error_count++;
      end
      if (got.switched !== exp_r.switched) begin
        $display("%0t: switched mismatch, expected %0d, got %0d",
                 $time, exp_r.switched, got.switched);
        error_count++;
      end
    endfunction

    // a random slot that is in use, or the boot task when the table is empty
    function logic [6:0] random_used_slot();
      int idx[$];
      foreach (used_map[i]) if (used_map[i]) idx.push_back(i);
      if (idx.size() == 0) return BOOT_TASK;
      return 7'(idx[$urandom_range(idx.size() - 1)]);
    endfunction

    function bit table_full();
      foreach (used_map[i]) if (!used_map[i]) return 1'b0;
      return 1'b1;
    endfunction

  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// testbench top for the ready task selector: clock, reset, command driver, result monitor
// depends on rts_pkg, rts_tb_pkg (outcome tracker) and ready_task_selector_unit
`timescale 1ns / 1ps

module tb_top;

  import rts_pkg::*;
  import rts_tb_pkg::*;

  localparam int RANDOM_CMDS = 1830;
  localparam int SETTLE_CYCLES = SLOTS + 16;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  rts_outcome_tracker tracker = new();

  ready_task_selector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor: a result transfers at the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_outcome(out_item);
  end

  // present a command and hold it until it transfers; start stays high on return
  task automatic send_cmd(input in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.take_command(it);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [6:0] slot,
                             input logic [7:0] prio_val, input logic [2:0] bst);
    in_item_t it;
    it.operation    = op;
    it.task_slot    = slot;
    it.priority_req = prio_val;
    it.block_state  = bst;
    send_cmd(it);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender off until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed commands aimed at live tasks, with some noise
  function automatic in_item_t random_cmd();
    in_item_t it;
    int       roll;
    int       create_pct;
    roll = $urandom_range(99);
    it.task_slot    = 7'($urandom_range(127));
    it.priority_req = 8'($urandom_range(255));
    it.block_state  = 3'($urandom_range(7));
    if (roll < 5) begin
      it.operation = 2'($urandom_range(3));
      return it;
    end
    // slow fill so that a sparse table is exercised for a long while
    create_pct = tracker.table_full() ? 3 : 6;
    roll = $urandom_range(99);
    if (roll < create_pct) it.operation = OP_CREATE;
    else if (roll < create_pct + 36) it.operation = OP_BLOCK;
    else if (roll < create_pct + 64) it.operation = OP_UNBLOCK;
    else it.operation = OP_YIELD;
    if (it.operation == OP_CREATE && $urandom_range(19) == 0) it.priority_req = '0;
    if (it.operation == OP_BLOCK) begin
      it.block_state = ($urandom_range(99) < 88) ? 3'($urandom_range(7, 2))
                                                 : 3'($urandom_range(1));
    end
    roll = $urandom_range(99);
    if (roll < 55) it.task_slot = tracker.random_used_slot();
    else if (roll < 77) it.task_slot = tracker.cur_task;
    else if (roll < 84) it.task_slot = BOOT_TASK;
    return it;
  endfunction

  // main sequence
  initial begin
    int burst_left;
    int guard;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing to schedule, state and slot errors
    send_fields(OP_YIELD,   7'd0,      8'd0,   3'd0);
    send_fields(OP_BLOCK,   BOOT_TASK, 8'd0,   3'd2);
    send_fields(OP_BLOCK,   BOOT_TASK, 8'd0,   ST_READY);
    send_fields(OP_BLOCK,   BOOT_TASK, 8'd0,   ST_RUNNING);
    send_fields(OP_UNBLOCK, 7'd0,      8'd0,   3'd0);
    // slot is checked before state
    send_fields(OP_BLOCK,   7'd127,    8'd255, ST_READY);
    send_fields(OP_UNBLOCK, 7'd65,     8'd0,   3'd0);
    // unblock of the running boot task keeps it current
    send_fields(OP_UNBLOCK, BOOT_TASK, 8'd0,   3'd0);
    send_fields(OP_YIELD,   7'd0,      8'd0,   3'd7);
    // zero priority and a tie at the top
    send_fields(OP_CREATE,  7'd0,      8'd0,   3'd0);
    send_fields(OP_CREATE,  7'd0,      8'd255, 3'd0);
    send_fields(OP_CREATE,  7'd0,      8'd255, 3'd0);
    send_fields(OP_YIELD,   7'd0,      8'd0,   3'd0);
    send_fields(OP_YIELD,   7'd0,      8'd0,   3'd0);
    send_fields(OP_BLOCK,   7'd1,      8'd0,   3'd7);
    send_fields(OP_BLOCK,   7'd2,      8'd0,   3'd3);
    send_fields(OP_UNBLOCK, 7'd0,      8'd0,   3'd0);
    // no other ready task left
    send_fields(OP_YIELD,   7'd0,      8'd0,   3'd0);
    send_fields(OP_BLOCK,   7'd0,      8'd0,   3'd4);
    send_fields(OP_UNBLOCK, 7'd1,      8'd0,   3'd0);
    send_fields(OP_YIELD,   7'd0,      8'd0,   3'd0);
    send_fields(OP_BLOCK,   BOOT_TASK, 8'd0,   3'd5);
    send_fields(OP_UNBLOCK, 7'd127,    8'd0,   3'd0);
    send_fields(OP_CREATE,  7'd127,    8'd128, 3'd7);
    drain_results();

    // random commands in bursts with random gaps
    burst_left = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS / 2) begin
        drain_results();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(30, 1);
        if ($urandom_range(3) != 0) idle_for($urandom_range(80, 1));
      end
      if (burst_left > 0) burst_left--;
      send_cmd(random_cmd());
    end
    start <= 1'b0;

    // wait out the owed results, then settle and check that none is outstanding
    guard = 0;
    while (tracker.pending_outcomes.size() != 0 && guard < 10 * SETTLE_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending_outcomes.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding",
               $time, tracker.pending_outcomes.size());
      tracker.error_count++;
    end

    $display("commands: create %0d, block %0d, unblock %0d, yield %0d; task switches %0d",
             tracker.op_hits[0], tracker.op_hits[1], tracker.op_hits[2],
             tracker.op_hits[3], tracker.switch_count);
    $display("outcomes: ok %0d, full %0d, no ready %0d, bad state %0d, bad slot %0d",
             tracker.status_hits[0], tracker.status_hits[1], tracker.status_hits[2],
             tracker.status_hits[3], tracker.status_hits[4]);
    if (tracker.error_count == 0) begin
      $display("[ready_task_selector_unit] OK");
    end else begin
      $display("[ready_task_selector_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("[ready_task_selector_unit] ERROR");
    $finish;
  end

endmodule
